// ----- rtl/u8fel_pkg.sv -----
`timescale 1ns / 1ps

package u8fel_pkg;

    // Fixed field widths
    localparam int BYTE_BITS = 8;
    localparam int OUT_BITS  = 32;
    localparam int WIDE_BITS = 64;

    // Byte classes of strict UTF-8
    localparam logic [BYTE_BITS-1:0] ASCII_MAX     = 8'h7F;
    localparam logic [BYTE_BITS-1:0] LEAD2_MIN     = 8'hC2;
    localparam logic [BYTE_BITS-1:0] LEAD2_MAX     = 8'hDF;
    localparam logic [BYTE_BITS-1:0] LEAD3_MIN     = 8'hE0;
    localparam logic [BYTE_BITS-1:0] LEAD3_MAX     = 8'hEF;
    localparam logic [BYTE_BITS-1:0] LEAD4_MIN     = 8'hF0;
    localparam logic [BYTE_BITS-1:0] LEAD4_MAX     = 8'hF4;
    localparam logic [BYTE_BITS-1:0] CONT_MASK     = 8'hC0;
    localparam logic [BYTE_BITS-1:0] CONT_TAG      = 8'h80;
    localparam logic [BYTE_BITS-1:0] SURR_LEAD     = 8'hED;
    localparam logic [BYTE_BITS-1:0] E0_SECOND_MIN = 8'hA0;
    localparam logic [BYTE_BITS-1:0] F0_SECOND_MIN = 8'h90;
    localparam logic [BYTE_BITS-1:0] LINE_FEED     = 8'h0A;

    // One byte of text
    typedef struct packed {
        logic [BYTE_BITS-1:0] text_byte;
        logic                 final_byte;
    } item_t;

    // Input register contents handed to the scanner
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    // One verdict for a whole text
    typedef struct packed {
        logic                text_valid;
        logic [OUT_BITS-1:0] fault_offset;
        logic [OUT_BITS-1:0] fault_end;
        logic [OUT_BITS-1:0] fault_line;
        logic [OUT_BITS-1:0] fault_column;
    } result_t;

endpackage

// ----- rtl/u8fel_text_if.sv -----
`timescale 1ns / 1ps

interface u8fel_text_if
    import u8fel_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] text_byte;
    logic                 final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ----- rtl/u8fel_result_if.sv -----
`timescale 1ns / 1ps

interface u8fel_result_if
    import u8fel_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                text_valid;
    logic [OUT_BITS-1:0] fault_offset;
    logic [OUT_BITS-1:0] fault_end;
    logic [OUT_BITS-1:0] fault_line;
    logic [OUT_BITS-1:0] fault_column;

    modport source (
        output valid, output text_valid, output fault_offset, output fault_end,
        output fault_line, output fault_column, input ready
    );
    modport sink (
        input valid, input text_valid, input fault_offset, input fault_end,
        input fault_line, input fault_column, output ready
    );
endinterface

// ----- rtl/u8fel_in_reg.sv -----
`timescale 1ns / 1ps

module u8fel_in_reg
    import u8fel_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    u8fel_text_if.sink        text,
    input  logic              adv,
    output stage_t            stage
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // Accept a new item whenever the held one leaves or the stage is empty
    assign text.ready = !valid_reg || adv;
    assign take       = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold control under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.text_byte  <= text.text_byte;
            item_reg.final_byte <= text.final_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ----- rtl/u8fel_scan.sv -----
`timescale 1ns / 1ps

module u8fel_scan
    import u8fel_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  stage_t  stage,
    output logic    emit,
    output result_t res
);

    localparam int CW = COUNT_BITS;
    typedef logic [CW-1:0] cnt_t;

    localparam cnt_t CNT_ZERO = '0;
    localparam cnt_t CNT_ONE  = CW'(1);

    // Saturating increment of a counter
    function automatic cnt_t sat_inc(input cnt_t v);
        return (&v) ? v : v + CNT_ONE;
    endfunction

    // Limit a counter value to the output width
    function automatic logic [OUT_BITS-1:0] clip(input cnt_t v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return (w > WIDE_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
    endfunction

    cnt_t                 pos_reg, pos_next;
    cnt_t                 seq_start_reg, seq_start_next;
    logic [1:0]           remain_reg, remain_next;
    logic [BYTE_BITS-1:0] lead_reg, lead_next;
    logic                 second_reg, second_next;
    cnt_t                 line_reg, line_next;
    cnt_t                 col_reg, col_next;
    cnt_t                 start_line_reg, start_line_next;
    cnt_t                 start_col_reg, start_col_next;
    logic                 fault_seen_reg, fault_seen_next;
    cnt_t                 fault_off_reg, fault_off_next;
    cnt_t                 fault_line_reg, fault_line_next;
    cnt_t                 fault_col_reg, fault_col_next;

    logic [BYTE_BITS-1:0] b;
    logic                 fin;
    logic                 bad;
    cnt_t                 end_v;

    assign b    = stage.item.text_byte;
    assign fin  = stage.item.final_byte;
    assign emit = adv && fin;

    // Decode the byte against the sequence in flight
    always_comb
    begin
        pos_next        = pos_reg;
        seq_start_next  = seq_start_reg;
        remain_next     = remain_reg;
        lead_next       = lead_reg;
        second_next     = second_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        fault_seen_next = fault_seen_reg;
        fault_off_next  = fault_off_reg;
        fault_line_next = fault_line_reg;
        fault_col_next  = fault_col_reg;
        bad             = 1'b0;

        if (!fault_seen_reg)
        begin
            if (remain_reg == 2'd0)
            begin
                // Start a new sequence at this lead byte
                seq_start_next  = pos_reg;
                start_line_next = line_reg;
                start_col_next  = col_reg;
                lead_next       = b;
                priority if (b <= ASCII_MAX)
                begin
                    remain_next = 2'd0;
                end
                else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
                begin
                    remain_next = 2'd1;
                end
                else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
                begin
                    remain_next = 2'd2;
                end
                else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
                begin
                    remain_next = 2'd3;
                end
                else
                begin
                    remain_next     = 2'd0;
                    fault_seen_next = 1'b1;
                    fault_off_next  = pos_reg;
                    fault_line_next = line_reg;
                    fault_col_next  = col_reg;
                end
                second_next = (remain_next != 2'd0);
            end
            else
            begin
                // Check a continuation byte, with the tighter second-byte ranges
                bad = (b & CONT_MASK) != CONT_TAG;
                if (second_reg)
                begin
                    if ((lead_reg == LEAD3_MIN && b < E0_SECOND_MIN) ||
                        (lead_reg == SURR_LEAD && b >= E0_SECOND_MIN) ||
                        (lead_reg == LEAD4_MIN && b < F0_SECOND_MIN) ||
                        (lead_reg == LEAD4_MAX && b >= F0_SECOND_MIN))
                    begin
                        bad = 1'b1;
                    end
                end
                second_next = 1'b0;
                if (bad)
                begin
                    remain_next     = 2'd0;
                    fault_seen_next = 1'b1;
                    fault_off_next  = seq_start_reg;
                    fault_line_next = start_line_reg;
                    fault_col_next  = start_col_reg;
                end
                else
                begin
                    remain_next = remain_reg - 2'd1;
                end
            end
        end

        // Advance position, line and column
        if (b == LINE_FEED)
        begin
            line_next = sat_inc(line_reg);
            col_next  = CNT_ONE;
        end
        else
        begin
            line_next = line_reg;
            col_next  = sat_inc(col_reg);
        end
        pos_next = sat_inc(pos_reg);

        // Flag a sequence cut off by the end of the text
        if (fin && !fault_seen_next && remain_next != 2'd0)
        begin
            fault_seen_next = 1'b1;
            fault_off_next  = seq_start_next;
            fault_line_next = start_line_next;
            fault_col_next  = start_col_next;
        end
    end

    // Form the verdict for a final byte
    always_comb
    begin
        end_v = sat_inc(fault_off_next);
        if (end_v > pos_next)
        begin
            end_v = pos_next;
        end
        res.text_valid = !fault_seen_next;
        if (fault_seen_next)
        begin
            res.fault_offset = clip(fault_off_next);
            res.fault_end    = clip(end_v);
            res.fault_line   = clip(fault_line_next);
            res.fault_column = clip(fault_col_next);
        end
        else
        begin
            res.fault_offset = clip(pos_next);
            res.fault_end    = clip(pos_next);
            res.fault_line   = clip(line_next);
            res.fault_column = clip(col_next);
        end
    end

    // Update state per item; return to reset after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= CNT_ZERO;
            seq_start_reg  <= CNT_ZERO;
            remain_reg     <= 2'd0;
            lead_reg       <= '0;
            second_reg     <= 1'b0;
            line_reg       <= CNT_ONE;
            col_reg        <= CNT_ONE;
            start_line_reg <= CNT_ONE;
            start_col_reg  <= CNT_ONE;
            fault_seen_reg <= 1'b0;
            fault_off_reg  <= CNT_ZERO;
            fault_line_reg <= CNT_ZERO;
            fault_col_reg  <= CNT_ZERO;
        end
        else if (adv)
        begin
            if (fin)
            begin
                pos_reg        <= CNT_ZERO;
                seq_start_reg  <= CNT_ZERO;
                remain_reg     <= 2'd0;
                lead_reg       <= '0;
                second_reg     <= 1'b0;
                line_reg       <= CNT_ONE;
                col_reg        <= CNT_ONE;
                start_line_reg <= CNT_ONE;
                start_col_reg  <= CNT_ONE;
                fault_seen_reg <= 1'b0;
                fault_off_reg  <= CNT_ZERO;
                fault_line_reg <= CNT_ZERO;
                fault_col_reg  <= CNT_ZERO;
            end
            else
            begin
                pos_reg        <= pos_next;
                seq_start_reg  <= seq_start_next;
                remain_reg     <= remain_next;
                lead_reg       <= lead_next;
                second_reg     <= second_next;
                line_reg       <= line_next;
                col_reg        <= col_next;
                start_line_reg <= start_line_next;
                start_col_reg  <= start_col_next;
                fault_seen_reg <= fault_seen_next;
                fault_off_reg  <= fault_off_next;
                fault_line_reg <= fault_line_next;
                fault_col_reg  <= fault_col_next;
            end
        end
    end

endmodule

// ----- rtl/u8fel_out_reg.sv -----
`timescale 1ns / 1ps

module u8fel_out_reg
    import u8fel_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  result_t         data,
    u8fel_result_if.source  result,
    output logic            hold
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Keep the verdict until the receiver takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign hold                = valid_reg && !result.ready;
    assign result.valid        = valid_reg;
    assign result.text_valid   = data_reg.text_valid;
    assign result.fault_offset = data_reg.fault_offset;
    assign result.fault_end    = data_reg.fault_end;
    assign result.fault_line   = data_reg.fault_line;
    assign result.fault_column = data_reg.fault_column;

endmodule

// ----- rtl/utf8_first_error_locator.sv -----
`timescale 1ns / 1ps
// Strict UTF-8 checker that locates the first bad sequence of a text.
// Channel text: one byte per item (text_byte, final_byte); final_byte marks
// the last byte of a text. Channel result: one item per text, sent for its
// final byte: text_valid, and the offset, span end, 1-based line and column
// of the first bad sequence (or the end-of-text position when valid).
// A final byte goes from the input register via the scanner to the result register.
// Throughput: one byte per cycle while no final byte waits, set by the single pass
// from the input register through decode and counters into the state registers.
// Counters are COUNT_BITS wide and saturate; outputs saturate at 32 bits.
// Reset clears both registers and sets the scanner to the start of a text;
// no result is pending afterwards. After each final byte the scanner starts
// over for the next text.
// Receiver stall: non-final bytes keep flowing since they give no result;
// a final byte waits in the input register while a result is not taken,
// and text.ready drops behind it.
module utf8_first_error_locator
    import u8fel_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    u8fel_text_if.sink      text,
    u8fel_result_if.source  result
);

    stage_t  stage;
    logic    adv;
    logic    emit;
    logic    hold;
    result_t res;

    // Advance the held item unless it is final and the result slot is busy
    assign adv = stage.valid && !(stage.item.final_byte && hold);

    u8fel_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .adv   (adv),
        .stage (stage)
    );

    u8fel_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .stage (stage),
        .emit  (emit),
        .res   (res)
    );

    u8fel_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (emit),
        .data   (res),
        .result (result),
        .hold   (hold)
    );

endmodule

// ----- dv/utf8_first_error_locator_test.sv -----
`timescale 1ns / 1ps

module utf8_first_error_locator_test;
    import u8fel_pkg::*;

    localparam int CNT_W          = 32;
    localparam int RESET_CYCLES   = 6;
    localparam int GAP_MAX        = 15;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TEXT_BYTES     = 1600;

    typedef logic [BYTE_BITS-1:0] text_q_t[$];

    // Track strict UTF-8 decode state and queue the verdict of every text
    class utf8_verdict_ledger;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] seq_start;
        logic [CNT_W-1:0] line_no;
        logic [CNT_W-1:0] col_no;
        logic [CNT_W-1:0] start_line;
        logic [CNT_W-1:0] start_col;
        logic [1:0]       remaining;
        logic [7:0]       lead;
        logic             second_due;
        logic             fault_seen;
        logic [CNT_W-1:0] fault_off;
        logic [CNT_W-1:0] fault_line_no;
        logic [CNT_W-1:0] fault_col_no;
        result_t          pending[$];
        int               failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            position      = '0;
            seq_start     = '0;
            remaining     = '0;
            lead          = '0;
            second_due    = 1'b0;
            line_no       = 1;
            col_no        = 1;
            start_line    = 1;
            start_col     = 1;
            fault_seen    = 1'b0;
            fault_off     = '0;
            fault_line_no = '0;
            fault_col_no  = '0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function logic [OUT_BITS-1:0] clip(logic [CNT_W-1:0] v);
            if (v > {OUT_BITS{1'b1}})
                return '1;
            return OUT_BITS'(v);
        endfunction

        // Keep only the first fault of a text
        function void flag_fault(logic [CNT_W-1:0] off, logic [CNT_W-1:0] ln,
                                 logic [CNT_W-1:0] col);
            if (fault_seen)
                return;
            fault_seen    = 1'b1;
            fault_off     = off;
            fault_line_no = ln;
            fault_col_no  = col;
        endfunction

        function void note_byte(logic [BYTE_BITS-1:0] b, logic last);
            logic             bad;
            logic [CNT_W-1:0] span_end;
            result_t          verdict;
            if (!fault_seen) begin
                if (remaining == 2'd0) begin
                    // Start a new sequence at this byte
                    seq_start  = position;
                    start_line = line_no;
                    start_col  = col_no;
                    lead       = b;
                    if (b <= ASCII_MAX)
                        remaining = 2'd0;
                    else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
                        remaining = 2'd1;
                    else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
                        remaining = 2'd2;
                    else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
                        remaining = 2'd3;
                    else
                        flag_fault(position, line_no, col_no);
                    second_due = (remaining != 2'd0);
                end
                else begin
                    // Check a continuation byte, with the range rules on the second
                    bad = (b & CONT_MASK) != CONT_TAG;
                    if (!bad && second_due)
                        bad = (lead == LEAD3_MIN && b < E0_SECOND_MIN) ||
                              (lead == SURR_LEAD && b >= E0_SECOND_MIN) ||
                              (lead == LEAD4_MIN && b < F0_SECOND_MIN) ||
                              (lead == LEAD4_MAX && b >= F0_SECOND_MIN);
                    second_due = 1'b0;
                    if (bad) begin
                        flag_fault(seq_start, start_line, start_col);
                        remaining = 2'd0;
                    end
                    else begin
                        remaining = remaining - 1'b1;
                    end
                end
            end

            // Advance line, column and offset
            if (b == LINE_FEED) begin
                line_no = bump(line_no);
                col_no  = 1;
            end
            else begin
                col_no = bump(col_no);
            end
            position = bump(position);

            if (!last)
                return;

            // Close the text: a cut-off sequence is a fault at its lead byte
            if (!fault_seen && remaining != 2'd0)
                flag_fault(seq_start, start_line, start_col);
            if (fault_seen) begin
                span_end = bump(fault_off);
                if (span_end > position)
                    span_end = position;
                verdict.text_valid   = 1'b0;
                verdict.fault_offset = clip(fault_off);
                verdict.fault_end    = clip(span_end);
                verdict.fault_line   = clip(fault_line_no);
                verdict.fault_column = clip(fault_col_no);
            end
            else begin
                verdict.text_valid   = 1'b1;
                verdict.fault_offset = clip(position);
                verdict.fault_end    = clip(position);
                verdict.fault_line   = clip(line_no);
                verdict.fault_column = clip(col_no);
            end
            pending.push_back(verdict);
            restart();
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("verdict arrived with none outstanding");
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.text_valid !== want.text_valid) begin
                $error("text_valid: expected %0d, got %0d", want.text_valid, got.text_valid);
                failures++;
            end
            if (got.fault_offset !== want.fault_offset) begin
                $error("fault_offset: expected %0d, got %0d",
                       want.fault_offset, got.fault_offset);
                failures++;
            end
            if (got.fault_end !== want.fault_end) begin
                $error("fault_end: expected %0d, got %0d", want.fault_end, got.fault_end);
                failures++;
            end
            if (got.fault_line !== want.fault_line) begin
                $error("fault_line: expected %0d, got %0d", want.fault_line, got.fault_line);
                failures++;
            end
            if (got.fault_column !== want.fault_column) begin
                $error("fault_column: expected %0d, got %0d",
                       want.fault_column, got.fault_column);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic rx_hold;
    int   bytes_taken = 0;
    int   idle_cycles = 0;

    utf8_verdict_ledger ledger = new();

    u8fel_text_if   text_ch();
    u8fel_result_if verdict_ch();

    utf8_first_error_locator #(
        .COUNT_BITS (CNT_W)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (verdict_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte after a gap and hold it until taken
    task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last, input int gap);
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= b;
        text_ch.final_byte <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input text_q_t t);
        bit quiet;
        quiet = ($urandom_range(0, 3) == 0);
        foreach (t[i])
            send_byte(t[i], i == t.size() - 1, quiet ? 0 : $urandom_range(0, GAP_MAX));
    endtask

    // Append one character; rough mode adds noise, broken and cut-off sequences
    function automatic void append_char(ref text_q_t t, input bit rough);
        int               kind;
        int               n;
        int               used;
        int               idx;
        logic [7:0]       seq[4];
        kind = $urandom_range(0, rough ? 109 : 99);
        if (kind >= 100) begin
            t.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 40) begin
            t.push_back(($urandom_range(0, 5) == 0) ? LINE_FEED : 8'($urandom_range(0, 127)));
            return;
        end
        for (int i = 1; i < 4; i++)
            seq[i] = 8'($urandom_range(8'h80, 8'hBF));
        if (kind < 55) begin
            n = 2;
            seq[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
        end
        else if (kind < 75) begin
            n = 3;
            case ($urandom_range(0, 3))
                0:       seq[0] = LEAD3_MIN;
                1:       seq[0] = SURR_LEAD;
                default: seq[0] = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
            endcase
            if (seq[0] == LEAD3_MIN)
                seq[1] = 8'($urandom_range(E0_SECOND_MIN, 8'hBF));
            else if (seq[0] == SURR_LEAD)
                seq[1] = 8'($urandom_range(8'h80, E0_SECOND_MIN - 1));
        end
        else begin
            n = 4;
            seq[0] = ($urandom_range(0, 2) == 0) ? LEAD4_MIN
                   : 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
            if (seq[0] == LEAD4_MIN)
                seq[1] = 8'($urandom_range(F0_SECOND_MIN, 8'hBF));
            else if (seq[0] == LEAD4_MAX)
                seq[1] = 8'($urandom_range(8'h80, F0_SECOND_MIN - 1));
        end
        used = n;
        if (rough && $urandom_range(0, 5) == 0) begin
            // Break one continuation byte, often the range-checked second one
            idx = $urandom_range(1, n - 1);
            if (idx == 1 && $urandom_range(0, 1) == 0) begin
                case (seq[0])
                    LEAD3_MIN: seq[1] = 8'($urandom_range(8'h80, E0_SECOND_MIN - 1));
                    SURR_LEAD: seq[1] = 8'($urandom_range(E0_SECOND_MIN, 8'hBF));
                    LEAD4_MIN: seq[1] = 8'($urandom_range(8'h80, F0_SECOND_MIN - 1));
                    LEAD4_MAX: seq[1] = 8'($urandom_range(F0_SECOND_MIN, 8'hBF));
                    default:   seq[1] = 8'($urandom_range(0, 255));
                endcase
            end
            else begin
                seq[idx] = 8'($urandom_range(0, 255));
            end
        end
        else if (rough && $urandom_range(0, 5) == 0) begin
            used = $urandom_range(1, n - 1);
        end
        for (int i = 0; i < used; i++)
            t.push_back(seq[i]);
    endfunction

    // Take verdicts, stalling between them at random
    task automatic drain_results();
        int stall;
        bit quiet;
        stall = 0;
        quiet = 1'b0;
        forever begin
            @(posedge clk);
            if (verdict_ch.valid && verdict_ch.ready) begin
                if ($urandom_range(0, 19) == 0)
                    quiet = !quiet;
                stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            else if (stall > 0) begin
                stall--;
            end
            verdict_ch.ready <= (stall == 0) && !rx_hold;
        end
    endtask

    initial drain_results();

    // Hold off the receiver once for a long stretch while bytes keep coming
    initial begin
        rx_hold <= 1'b0;
        wait (bytes_taken >= HOLD_AFTER);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Monitor both channels
    always @(posedge clk) begin
        result_t got;
        if (rst_n) begin
            if (text_ch.valid && text_ch.ready) begin
                ledger.note_byte(text_ch.text_byte, text_ch.final_byte);
                bytes_taken++;
            end
            if (verdict_ch.valid && verdict_ch.ready) begin
                got.text_valid   = verdict_ch.text_valid;
                got.fault_offset = verdict_ch.fault_offset;
                got.fault_end    = verdict_ch.fault_end;
                got.fault_line   = verdict_ch.fault_line;
                got.fault_column = verdict_ch.fault_column;
                ledger.check_result(got);
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (text_ch.valid && text_ch.ready) ||
            (verdict_ch.valid && verdict_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        text_q_t t;
        int      sent;
        int      nchars;
        bit      rough;
        rst_n              <= 1'b0;
        text_ch.valid      <= 1'b0;
        text_ch.text_byte  <= '0;
        text_ch.final_byte <= 1'b0;
        verdict_ch.ready   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: byte extremes, line feed, overlong, surrogate,
        // above-range, cut-off, stray continuation and repeated faults
        t = '{8'h00};                      send_text(t);
        t = '{8'hFF};                      send_text(t);
        t = '{LINE_FEED, 8'hC2, 8'h80};    send_text(t);
        t = '{8'hE0, 8'h9F, 8'h80};        send_text(t);
        t = '{8'hED, 8'hA0, 8'h80};        send_text(t);
        t = '{8'hF0, 8'h8F};               send_text(t);
        t = '{8'hF4, 8'h90};               send_text(t);
        t = '{8'h41, 8'hE2, 8'h82};        send_text(t);
        t = '{8'h80};                      send_text(t);
        t = '{8'hC0, 8'hC1};               send_text(t);
        t = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text(t);

        // Random texts, mostly well-formed
        sent = 0;
        while (sent < TEXT_BYTES) begin
            t.delete();
            rough  = ($urandom_range(0, 4) == 0);
            nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                   : $urandom_range(1, 10);
            for (int i = 0; i < nchars; i++)
                append_char(t, rough);
            send_text(t);
            sent += t.size();
        end
        text_ch.valid <= 1'b0;

        // Let the monitor note the last byte before counting what is outstanding
        @(posedge clk);
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
